// ----- hdl/tcw_pkg.sv -----
// Shared constants, types and helpers of the text console writer.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam int ACT_W  = 3;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  // Wide enough for any linear position and for the cell count itself.
  localparam int LIN_W  = ROW_W + COL_W + 1;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  localparam logic [ACT_W-1:0] ACT_PRINT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_BKSP  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CR    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_CLEAR,
    ST_SCROLL,
    ST_DRAIN,
    ST_ZERO
  } tcw_state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } tcw_ram_req_t;

  function automatic logic [LIN_W-1:0] cell_pos(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    return LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
  endfunction

endpackage

// ----- hdl/text_console_writer_core.sv -----
// Top level of the text console writer: register port, sequencer and cell store.
// The result strobe follows the execute step for print, newline, backspace, carriage
// return and unused actions; a read of a cell in range adds a read-wait step, a clear
// adds a sweep over every cell, and an item that scrolls adds a row copy, drain and zeroing.
// Commands are taken only while idle, so a new item waits until the last one is done.
// Reset: synchronous; busy stays high through a pass that zeroes every cell.
module text_console_writer_core import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Command channel.
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [IDX_W-1:0]  in_cell_index,
  // Result channel; every word is shown for a single cycle.
  output logic              out_valid,
  output logic [POS_W-1:0]  out_cursor_pos,
  output logic [CHAR_W-1:0] out_read_char,
  output logic [ATTR_W-1:0] out_read_attr,
  // Register port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [ATTR_W-1:0] attr_r;
  logic              attr_sel;
  tcw_ram_req_t      ram_req;
  logic [CELL_W-1:0] ram_rdata;

  // The attribute register is the only one; it sits in the first word, and
  // anything in the second word reads as zero and ignores writes.
  assign attr_sel = !paddr[2];
  assign pready   = 1'b1;
  assign prdata   = attr_sel ? {24'd0, attr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= 8'd7;
    end else if (psel && penable && pwrite && attr_sel) begin
      attr_r <= pwdata[ATTR_W-1:0];
    end
  end

  // The sequencer owns the cursor and drives every access to the store.
  tcw_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_action      (in_action),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .attr           (attr_r),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_cursor_pos (out_cursor_pos),
    .out_read_char  (out_read_char),
    .out_read_attr  (out_read_attr),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata)
  );

  // Character byte in the low half of each cell, attribute in the high half.
  tcw_cell_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

// ----- hdl/tcw_cell_ram.sv -----
// Screen cell store: one write port and one registered read port.
module tcw_cell_ram import tcw_pkg::*; (
  input  logic              clk,
  input  tcw_ram_req_t      req,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/tcw_seq.sv -----
// Command sequencer: cursor, cell writes, scroll copy and clear sweeps.
module tcw_seq import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [IDX_W-1:0]  in_cell_index,
  input  logic [ATTR_W-1:0] attr,
  output logic              busy,
  output logic              out_valid,
  output logic [POS_W-1:0]  out_cursor_pos,
  output logic [CHAR_W-1:0] out_read_char,
  output logic [ATTR_W-1:0] out_read_attr,
  output tcw_ram_req_t      ram_req,
  input  logic [CELL_W-1:0] ram_rdata
);

  tcw_state_t        state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] rd_char_r, rd_char_nxt;
  logic [ATTR_W-1:0] rd_attr_r, rd_attr_nxt;
  logic [ACT_W-1:0]  act_r;
  logic [CHAR_W-1:0] code_r;
  logic [IDX_W-1:0]  idx_r;

  logic              accept;
  logic              at_line_end;
  logic              at_last_row;
  logic              need_scroll;
  logic              idx_in_range;
  logic              ptr_last;
  logic              copy_last;
  logic [COL_W-1:0]  bs_col;
  logic [LIN_W-1:0]  here_pos;
  logic [LIN_W-1:0]  bs_pos;
  logic [LIN_W-1:0]  idx_ext;

  assign accept       = start && !busy;
  assign busy         = (state_r != ST_IDLE);
  assign at_line_end  = (col_r == COL_W'(COLUMNS - 1));
  assign at_last_row  = (row_r == ROW_W'(ROWS - 1));
  assign need_scroll  = (act_r == ACT_PRINT) && at_last_row &&
                        ((code_r == NEWLINE_CODE) || at_line_end);
  assign idx_ext      = LIN_W'(idx_r);
  assign idx_in_range = (idx_ext < LIN_W'(CELL_COUNT));
  assign ptr_last     = (ptr_r == ADDR_W'(CELL_COUNT - 1));
  assign copy_last    = (ptr_r == ADDR_W'(CELL_COUNT - COLUMNS - 1));
  assign bs_col       = (col_r == '0) ? '0 : col_r - 1'b1;
  assign here_pos     = cell_pos(row_r, col_r);
  assign bs_pos       = cell_pos(row_r, bs_col);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (ptr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (act_r == ACT_CLEAR) begin
          state_nxt = ST_CLEAR;
        end else if (act_r == ACT_READ && idx_in_range) begin
          state_nxt = ST_RDWAIT;
        end else if (need_scroll) begin
          state_nxt = ST_SCROLL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDWAIT: state_nxt = ST_IDLE;
      ST_CLEAR: begin
        if (ptr_last) state_nxt = ST_IDLE;
      end
      ST_SCROLL: begin
        if (copy_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_ZERO;
      ST_ZERO: begin
        if (ptr_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory requests.
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    ptr_nxt       = ptr_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    out_valid_nxt = 1'b0;
    rd_char_nxt   = rd_char_r;
    rd_attr_nxt   = rd_attr_r;
    ram_req       = '0;

    unique case (state_r)
      ST_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ptr_r;
        ptr_nxt       = ptr_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) ptr_nxt = '0;
      end
      ST_EXEC: begin
        rd_char_nxt = '0;
        rd_attr_nxt = '0;
        unique case (act_r)
          ACT_PRINT: begin
            if (code_r != NEWLINE_CODE) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = here_pos[ADDR_W-1:0];
              ram_req.wdata = {attr, code_r};
            end
            if (code_r == NEWLINE_CODE || at_line_end) begin
              col_nxt = '0;
              if (!at_last_row) row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
          ACT_BKSP: begin
            col_nxt       = bs_col;
            ram_req.we    = 1'b1;
            ram_req.waddr = bs_pos[ADDR_W-1:0];
            ram_req.wdata = {attr, CHAR_W'(0)};
          end
          ACT_CR: col_nxt = '0;
          ACT_CLEAR: begin
            col_nxt = '0;
            row_nxt = '0;
          end
          ACT_READ: begin
            ram_req.re    = idx_in_range;
            ram_req.raddr = idx_ext[ADDR_W-1:0];
          end
          default: ;
        endcase
        out_valid_nxt = (state_nxt == ST_IDLE);
      end
      ST_RDWAIT: begin
        rd_char_nxt   = ram_rdata[CHAR_W-1:0];
        rd_attr_nxt   = ram_rdata[CELL_W-1:CHAR_W];
        out_valid_nxt = 1'b1;
      end
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ptr_r;
        ram_req.wdata = {attr, CHAR_W'(0)};
        ptr_nxt       = ptr_r + 1'b1;
        out_valid_nxt = ptr_last;
      end
      ST_SCROLL: begin
        // Read one row ahead and write back the word fetched last cycle.
        ram_req.re    = 1'b1;
        ram_req.raddr = ptr_r + ADDR_W'(COLUMNS);
        ram_req.we    = wr_pend_r;
        ram_req.waddr = wr_addr_r;
        ram_req.wdata = ram_rdata;
        wr_pend_nxt   = 1'b1;
        wr_addr_nxt   = ptr_r;
        ptr_nxt       = ptr_r + 1'b1;
      end
      ST_DRAIN: begin
        ram_req.we    = wr_pend_r;
        ram_req.waddr = wr_addr_r;
        ram_req.wdata = ram_rdata;
      end
      ST_ZERO: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ptr_r;
        ptr_nxt       = ptr_r + 1'b1;
        out_valid_nxt = ptr_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      col_r       <= '0;
      row_r       <= '0;
      ptr_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ptr_r       <= ptr_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
    rd_char_r <= rd_char_nxt;
    rd_attr_r <= rd_attr_nxt;
    if (accept) begin
      act_r  <= in_action;
      code_r <= in_char_code;
      idx_r  <= in_cell_index;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = here_pos[POS_W-1:0];
  assign out_read_char  = rd_char_r;
  assign out_read_attr  = rd_attr_r;

`ifndef ASSERT_OFF
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= ROW_W'(ROWS - 1)) && (col_r <= COL_W'(COLUMNS - 1)))
    else $error("cursor left the screen");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted word did not start execution");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  a_scroll_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL && wr_pend_r) |-> (wr_addr_r < ram_req.raddr))
    else $error("scroll write overtook its read");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_req.we)
    else $error("cell store written while idle");
`endif

endmodule

// ----- tb/text_console_writer_core_tb.sv -----
// Self-checking testbench for the text console writer core: random command stream with a cell-store predictor.
module text_console_writer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  // Register map: the attribute register sits at byte address 0. Address 4 decodes
  // to no register, so a write there must leave the attribute alone.
  localparam logic [2:0] ATTR_ADDR  = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  // Action codes above the read action do nothing but report the cursor.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_MID = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [CHAR_W-1:0] code;
    logic [IDX_W-1:0]  idx;
  } command_t;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
  } console_word_t;

  // Mirror of the screen: the cell store, the cursor and the attribute register.
  // Every accepted command updates the mirror and queues the word the block owes us.
  class screen_tracker;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    int unsigned       col;
    int unsigned       row;
    logic [ATTR_W-1:0] attr;
    console_word_t     expected_words [$];
    int                mismatches;

    function new();
      foreach (cells[i]) cells[i] = '0;
      col = 0;
      row = 0;
      attr = 8'd7;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns: MISMATCH %s", $time, msg);
    endfunction

    function int unsigned cursor();
      return row * COLUMNS + col;
    endfunction

    // Moving off the bottom row shifts every row up and leaves a zeroed bottom row.
    function void next_row();
      col = 0;
      if (row == ROWS - 1) begin
        for (int i = 0; i < CELL_COUNT - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) cells[i] = '0;
      end else begin
        row++;
      end
    endfunction

    function void note_command(command_t c);
      console_word_t w;
      w.ch = '0;
      w.attr = '0;
      case (c.act)
        ACT_PRINT: begin
          if (c.code == NEWLINE_CODE) begin
            next_row();
          end else begin
            cells[cursor()] = {attr, c.code};
            col++;
            if (col >= COLUMNS) next_row();
          end
        end
        ACT_BKSP: begin
          if (col > 0) col--;
          cells[cursor()] = {attr, CHAR_W'(0)};
        end
        ACT_CR: col = 0;
        ACT_CLEAR: begin
          foreach (cells[i]) cells[i] = {attr, CHAR_W'(0)};
          col = 0;
          row = 0;
        end
        ACT_READ: begin
          if (c.idx < CELL_COUNT) {w.attr, w.ch} = cells[c.idx];
        end
        default: ;
      endcase
      w.pos = POS_W'(cursor());
      expected_words.push_back(w);
    endfunction

    function void check_word(logic [POS_W-1:0] pos, logic [CHAR_W-1:0] ch,
                             logic [ATTR_W-1:0] at);
      console_word_t w;
      if (expected_words.size() == 0) begin
        flag($sformatf("unexpected word: pos %0d char %02h attr %02h", pos, ch, at));
        return;
      end
      w = expected_words.pop_front();
      if (pos !== w.pos || ch !== w.ch || at !== w.attr)
        flag($sformatf("pos exp %0d got %0d, char exp %02h got %02h, attr exp %02h got %02h",
                       w.pos, pos, w.ch, ch, w.attr, at));
    endfunction
  endclass

  // All inputs start at known values, and reset starts out low.
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [ACT_W-1:0]  in_action = '0;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [IDX_W-1:0]  in_cell_index = '0;
  logic              out_valid;
  logic [POS_W-1:0]  out_cursor_pos;
  logic [CHAR_W-1:0] out_read_char;
  logic [ATTR_W-1:0] out_read_attr;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  screen_tracker tracker = new();

  text_console_writer_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .out_valid     (out_valid),
    .out_cursor_pos(out_cursor_pos),
    .out_read_char (out_read_char),
    .out_read_attr (out_read_attr),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Clears and scrolls walk the whole store. The bound covers every command taking
  // as long as a clear or a scroll, several times over.
  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // The block cannot hold a result word back, so every strobe is checked at the edge
  // that ends its cycle. Reading at the edge sees the values from before the edge,
  // which keeps the check independent of event order within the time step.
  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_word(out_cursor_pos, out_read_char, out_read_attr);
  end

  // Present one command and hold it until an edge sees start high with busy low.
  // start is left high so that a following command goes out without a bubble.
  task automatic send_command(input command_t c);
    start         <= 1'b1;
    in_action     <= c.act;
    in_char_code  <= c.code;
    in_cell_index <= c.idx;
    do @(posedge clk); while (busy);
    tracker.note_command(c);
  endtask

  // Sender idling: each cycle is idle with the given percent chance, so gaps have
  // random lengths and land on every stage of the block's work.
  task automatic pause(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // One register transfer: a setup phase, then access until pready is seen, then
  // the bus returns to idle.
  task automatic cfg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr && addr == ATTR_ADDR) tracker.attr = data[ATTR_W-1:0];
    @(posedge clk);
  endtask

  // Write a register, then read the attribute back to confirm what the block holds.
  task automatic cfg_update(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] rd;
    cfg_access(1'b1, addr, data, rd);
    cfg_access(1'b0, ATTR_ADDR, '0, rd);
    if (rd !== 32'(tracker.attr))
      tracker.flag($sformatf("attribute readback exp %02h got %08h", tracker.attr, rd));
  endtask

  // Wait until the block owes nothing and has dropped busy, so that a register
  // write cannot land in the middle of a command.
  task automatic settle();
    start <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random traffic built from bursts that look like real console use: runs of text
  // with the odd newline, newline runs that push the cursor to the bottom and make
  // it scroll, editing, reads near the cursor, an occasional clear and some noise.
  task automatic run_phase(input int target, input int gap_pct);
    int       sent;
    int       kind;
    int       len;
    int       p;
    int       r;
    command_t c;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(99);
      if (kind < 35)      len = $urandom_range(1, 60);
      else if (kind < 47) len = $urandom_range(1, 8);
      else if (kind < 67) len = $urandom_range(1, 5);
      else if (kind < 92) len = $urandom_range(1, 4);
      else if (kind < 95) len = 1;
      else                len = $urandom_range(1, 3);
      repeat (len) begin
        c.code = CHAR_W'($urandom);
        c.idx  = IDX_W'($urandom);
        if (kind < 35) begin
          c.act = ACT_PRINT;
          if ($urandom_range(99) < 3) c.code = NEWLINE_CODE;
        end else if (kind < 47) begin
          c.act  = ACT_PRINT;
          c.code = NEWLINE_CODE;
        end else if (kind < 67) begin
          c.act = $urandom_range(1) ? ACT_BKSP : ACT_CR;
        end else if (kind < 92) begin
          // Mostly read what was just written; sometimes anywhere, sometimes past the end.
          c.act = ACT_READ;
          p = tracker.cursor();
          r = $urandom_range(9);
          if (r < 6)      c.idx = IDX_W'(p - $urandom_range(p < 160 ? p : 160));
          else if (r < 9) c.idx = IDX_W'($urandom_range(CELL_COUNT - 1));
          else            c.idx = IDX_W'($urandom_range(CELL_COUNT, 2 ** IDX_W - 1));
        end else if (kind < 95) begin
          c.act = ACT_CLEAR;
        end else begin
          c.act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end
        send_command(c);
        pause(gap_pct);
        sent++;
      end
    end
  endtask

  initial begin
    command_t script [$];
    // Directed opening: reset contents, the byte extremes, backspace in mid-line and
    // clamped at column zero, carriage return, newline, reads at both ends of the store
    // and beyond it, every unused action, and a clear followed by a read of a blank.
    script = '{
      '{ACT_READ,     8'h00, 11'd0},
      '{ACT_PRINT,    8'h41, 11'd0},
      '{ACT_PRINT,    8'hFF, 11'h7FF},
      '{ACT_PRINT,    8'h00, 11'd0},
      '{ACT_READ,     8'h00, 11'd1},
      '{ACT_BKSP,     8'h00, 11'd0},
      '{ACT_READ,     8'h00, 11'd2},
      '{ACT_CR,       8'h00, 11'd0},
      '{ACT_BKSP,     8'hFF, 11'h7FF},
      '{ACT_READ,     8'h00, 11'd0},
      '{ACT_PRINT,    NEWLINE_CODE, 11'd0},
      '{ACT_PRINT,    8'h7E, 11'd0},
      '{ACT_READ,     8'h00, 11'd80},
      '{ACT_READ,     8'h00, 11'd1999},
      '{ACT_READ,     8'h00, 11'd2000},
      '{ACT_READ,     8'hFF, 11'h7FF},
      '{ACT_SPARE_LO, 8'h00, 11'd0},
      '{ACT_SPARE_MID, 8'h55, 11'h2AA},
      '{ACT_SPARE_HI, 8'hFF, 11'h7FF},
      '{ACT_CLEAR,    8'h00, 11'd0},
      '{ACT_READ,     8'h00, 11'd81},
      '{ACT_PRINT,    8'h80, 11'd0}
    };

    // The block spends a full pass zeroing the store after reset; wait it out.
    do @(posedge clk); while (!rst_n || busy);

    // All-ones on the bus for the first write: only the low byte may stick.
    cfg_update(ATTR_ADDR, 32'hFFFF_FFFF);
    foreach (script[i]) begin
      send_command(script[i]);
      pause(23);
    end

    settle();
    cfg_update(ATTR_ADDR, 32'h0000_0000);
    run_phase(660, 23);

    settle();
    cfg_update(ATTR_ADDR, 32'($urandom_range(1, 254)));
    run_phase(660, 78);

    // A write to an undecoded address must not disturb the attribute.
    settle();
    cfg_update(SPARE_ADDR, $urandom);
    cfg_update(ATTR_ADDR, 32'($urandom_range(1, 254)));
    run_phase(660, 0);

    start <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
